[hw/rtl/mrge_pkg.sv]
// Shared types, constants and helpers of the mixed-radix Gray enumerator.
// Used by mrge_cell and by the top level; depends on nothing else.
package mrge_pkg;

  // Field and storage widths
  localparam int DIGIT_W    = 4;   // one digit value
  localparam int RADIX_W    = 5;   // radix register, 1..16
  localparam int POS_W      = 16;  // step position and go_to target
  localparam int TOTAL_W    = 17;  // product of radices, up to 16**4
  localparam int COUNT_W    = 16;  // per-digit move count
  localparam int MODE_W     = 2;
  localparam int CHG_IDX_W  = 2;   // changed_digit field
  localparam int CFG_IDX_W  = 3;
  localparam int RADIX_REGS = 4;
  localparam int RREG_IDX_W = 2;
  localparam int MAX_RADIX  = 16;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 48;

  // Item commands
  typedef enum logic [MODE_W-1:0] {
    MODE_STEP    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_GOTO    = 2'd2
  } mode_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX_0 = 3'd0,
    REG_RADIX_1 = 3'd1,
    REG_RADIX_2 = 3'd2,
    REG_RADIX_3 = 3'd3,
    REG_REVERSE = 3'd4,
    REG_FROZEN  = 3'd5
  } cfg_reg_t;

  // Controller state
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic restart;  // relatch radix, clear digit state
    logic count;    // advance the position counter digits
  } cell_ctrl_t;

  // Result item, advanced in the lowest bit
  typedef struct packed {
    logic                 bad_target;
    logic                 at_end;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   change_total;
    logic [DIGIT_W-1:0]   changed_value;
    logic [CHG_IDX_W-1:0] changed_digit;
    logic                 changed_valid;
    logic                 advanced;
  } result_t;

  // Clamp a raw radix register to 1..MAX_RADIX
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r == '0) begin
      e = RADIX_W'(1);
    end else if (r > RADIX_W'(MAX_RADIX)) begin
      e = RADIX_W'(MAX_RADIX);
    end
    return e;
  endfunction

endpackage

[hw/rtl/mrge_cell.sv]
// One digit cell: position-counter digit, Gray digit with direction and move
// count, and one stage of the place-value product chain. Uses mrge_pkg.
module mrge_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  mrge_pkg::cell_ctrl_t               ctrl,
  input  logic                               carry_in,
  input  logic                               gray_move,
  input  logic [mrge_pkg::RADIX_W-1:0]       radix_eff,
  input  logic [mrge_pkg::TOTAL_W-1:0]       prod_in,
  output logic                               carry_out,
  output logic                               stop,
  output logic                               at_max,
  output logic [mrge_pkg::TOTAL_W-1:0]       prod_out,
  output logic [mrge_pkg::DIGIT_W-1:0]       value,
  output logic [mrge_pkg::COUNT_W-1:0]       moves
);
  import mrge_pkg::*;

  logic [RADIX_W-1:0]         radix_lat;
  logic [DIGIT_W-1:0]         count_digit;
  logic [DIGIT_W-1:0]         gray_digit;
  logic                       dir_down;
  logic [COUNT_W-1:0]         moves_r;
  logic [TOTAL_W-1:0]         prod;
  logic [DIGIT_W-1:0]         gray_next;
  logic [TOTAL_W+RADIX_W-1:0] prod_full;
  logic                       turn;

  // Counter digit rolls over at latched radix-1; a radix of one always carries
  assign at_max    = RADIX_W'(count_digit) == (radix_lat - RADIX_W'(1));
  assign carry_out = carry_in & at_max;
  assign stop      = carry_in & ~at_max;

  // Gray digit moves one unit and turns around at either end of the live radix
  assign gray_next = dir_down ? (gray_digit - DIGIT_W'(1)) : (gray_digit + DIGIT_W'(1));
  assign turn      = (gray_next == '0) || (RADIX_W'(gray_next) == (radix_eff - RADIX_W'(1)));

  // Place-value stage: product of all radices up to and including this digit
  assign prod_full = prod_in * radix_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_lat   <= RADIX_W'(1);
      count_digit <= '0;
      gray_digit  <= '0;
      dir_down    <= 1'b0;
      moves_r     <= '0;
      prod        <= TOTAL_W'(1);
    end else begin
      prod <= prod_full[TOTAL_W-1:0];
      if (ctrl.restart) begin
        radix_lat   <= radix_eff;
        count_digit <= '0;
        gray_digit  <= '0;
        dir_down    <= 1'b0;
        moves_r     <= '0;
      end else begin
        // advance the counter digit where the carry reaches it
        if (ctrl.count && carry_in) begin
          count_digit <= at_max ? '0 : (count_digit + DIGIT_W'(1));
        end
        // move the Gray digit and count the move
        if (gray_move) begin
          gray_digit <= gray_next;
          moves_r    <= moves_r + COUNT_W'(1);
          if (turn) begin
            dir_down <= ~dir_down;
          end
        end
      end
    end
  end

  assign prod_out = prod;
  assign value    = gray_digit;
  assign moves    = moves_r;

endmodule

[hw/rtl/mixed_radix_gray_enumerator_top.sv]
// Mixed-radix Gray enumerator: a row of mrge_cell digits plus the item controller.
// Step and restart items go through the report state to the output register; the next item
// is taken only back in idle. A go_to walks one carry-chain step per cycle, then reports.
// After a restart s_tready stays low while settle runs down and place-value products
// ripple down the cell row. Reset is synchronous: all digits 0, radices 1, position 0.
module mixed_radix_gray_enumerator_top #(
  parameter int NUM_DIGITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mrge_pkg::S_DATA_W-1:0]     s_tdata,   // target[15:0]
  input  logic [mrge_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // advanced[0], changed_valid[1], changed_digit[3:2], changed_value[7:4],
  // change_total[23:8], position[39:24], at_end[40], bad_target[41], zero above
  output logic [mrge_pkg::M_DATA_W-1:0]     m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrge_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrge_pkg::RADIX_W-1:0]      cfg_data
);
  import mrge_pkg::*;

  localparam int IDX_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int SETTLE_W = $clog2(NUM_DIGITS + 1);

  // Configuration
  logic [RADIX_W-1:0] radix_reg [RADIX_REGS];
  logic               reverse_order;
  logic               frozen;

  // Controller state
  state_t               state;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     start_pos;
  logic [POS_W-1:0]     tgt;
  logic [IDX_W-1:0]     last_moved;
  logic                 last_valid;
  logic                 adv_r;
  logic                 bad_r;
  logic [SETTLE_W-1:0]  settle;

  // Cell row
  cell_ctrl_t           ctrl;
  logic [NUM_DIGITS:0]  carry;
  logic [NUM_DIGITS-1:0] stop_vec;
  logic [NUM_DIGITS-1:0] max_vec;
  logic [NUM_DIGITS-1:0] move_vec;
  logic [TOTAL_W-1:0]   prod [NUM_DIGITS+1];
  logic [DIGIT_W-1:0]   vals [NUM_DIGITS];
  logic [COUNT_W-1:0]   moves [NUM_DIGITS];

  // Decode
  mode_t                in_mode;
  logic [POS_W-1:0]     target;
  logic                 accept;
  logic                 at_end;
  logic                 bad_now;
  logic                 behind;
  logic                 step_now;
  logic                 restart_now;
  logic [IDX_W-1:0]     moved_idx;
  logic                 out_free;
  result_t              report;

  assign in_mode   = mode_t'(s_tuser);
  assign target    = s_tdata;
  assign s_tready  = (state == ST_IDLE) && (settle == '0);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign at_end    = &max_vec;
  assign bad_now   = TOTAL_W'(target) >= prod[NUM_DIGITS];
  assign behind    = target < pos;
  assign out_free  = !m_tvalid || m_tready;

  // Decide whether this cycle steps or restarts
  always_comb begin
    step_now    = 1'b0;
    restart_now = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_STEP:    step_now    = !frozen && !at_end;
            MODE_RESTART: restart_now = 1'b1;
            MODE_GOTO:    restart_now = !bad_now && !frozen && behind;
            default:      ;
          endcase
        end
      end
      ST_WALK:   step_now = (pos != tgt) && !at_end;
      ST_REPORT: ;
      default:   ;
    endcase
  end

  assign ctrl.restart = restart_now;
  assign ctrl.count   = step_now;
  assign carry[0]     = 1'b1;
  assign prod[0]      = TOTAL_W'(1);

  // Build the cell row; the Gray move goes to the mirrored cell when reversed
  for (genvar j = 0; j < NUM_DIGITS; j++) begin : g_cell
    logic [RADIX_W-1:0] radix_eff;
    if (j < RADIX_REGS) begin : g_reg
      assign radix_eff = eff_radix(radix_reg[j]);
    end else begin : g_one
      assign radix_eff = RADIX_W'(1);
    end

    assign move_vec[j] = step_now &&
                         (reverse_order ? stop_vec[NUM_DIGITS-1-j] : stop_vec[j]);

    mrge_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .carry_in  (carry[j]),
      .gray_move (move_vec[j]),
      .radix_eff (radix_eff),
      .prod_in   (prod[j]),
      .carry_out (carry[j+1]),
      .stop      (stop_vec[j]),
      .at_max    (max_vec[j]),
      .prod_out  (prod[j+1]),
      .value     (vals[j]),
      .moves     (moves[j])
    );
  end

  // Encode the moved cell
  always_comb begin
    moved_idx = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (move_vec[j]) begin
        moved_idx = IDX_W'(j);
      end
    end
  end

  // Assemble the result item from settled state
  always_comb begin
    report               = '0;
    report.advanced      = adv_r;
    report.changed_valid = last_valid;
    if (last_valid) begin
      report.changed_digit = CHG_IDX_W'(last_moved);
      report.changed_value = vals[last_moved];
      report.change_total  = moves[last_moved];
    end
    report.position   = pos;
    report.at_end     = at_end;
    report.bad_target = bad_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RADIX_REGS; i++) begin
        radix_reg[i] <= RADIX_W'(1);
      end
      reverse_order <= 1'b0;
      frozen        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RADIX_0, REG_RADIX_1, REG_RADIX_2, REG_RADIX_3: begin
          radix_reg[cfg_index[RREG_IDX_W-1:0]] <= cfg_data;
        end
        REG_REVERSE: reverse_order <= cfg_data[0];
        REG_FROZEN:  frozen        <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Position, last move and settle counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      last_valid <= 1'b0;
      last_moved <= '0;
      settle     <= '0;
    end else begin
      if (restart_now) begin
        pos        <= '0;
        last_valid <= 1'b0;
        last_moved <= '0;
      end else if (step_now) begin
        pos        <= pos + POS_W'(1);
        last_valid <= 1'b1;
        last_moved <= moved_idx;
      end else if (state == ST_WALK) begin
        // go_to done: it reports no single digit
        last_valid <= 1'b0;
        last_moved <= '0;
      end
      if (restart_now) begin
        settle <= SETTLE_W'(NUM_DIGITS);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  // Item sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      adv_r <= 1'b0;
      bad_r <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // a step reports its own advance; a go_to flags a bad target, walks, or reports if frozen
            adv_r <= (in_mode == MODE_STEP) && step_now;
            bad_r <= (in_mode == MODE_GOTO) && bad_now;
            if ((in_mode == MODE_GOTO) && !bad_now && !frozen) begin
              state <= ST_WALK;
            end else begin
              state <= ST_REPORT;
            end
          end
        end
        ST_WALK: begin
          if (!step_now) begin
            adv_r <= pos != start_pos;
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the go_to start point and target
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      start_pos <= pos;
      tgt       <= target;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_REPORT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPORT && out_free) begin
      m_tdata <= {(M_DATA_W - $bits(result_t))'(0), report};
    end
  end

  // Checks
  a_step_xor_restart: assert property (@(posedge clk) disable iff (rst)
    !(step_now && restart_now))
    else $error("step and restart in the same cycle");

  a_one_stop: assert property (@(posedge clk) disable iff (rst)
    step_now |-> $onehot(stop_vec) && $onehot(move_vec))
    else $error("carry chain did not select exactly one digit");

  a_pos_inc: assert property (@(posedge clk) disable iff (rst)
    step_now |=> pos == ($past(pos) + POS_W'(1)))
    else $error("position did not advance by one after a step");

  a_out_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_REPORT))
    else $error("result item raised outside the report state");

  a_no_step_at_end: assert property (@(posedge clk) disable iff (rst)
    at_end |-> !step_now)
    else $error("step taken at the last combination");

  a_end_chain: assert property (@(posedge clk) disable iff (rst)
    carry[NUM_DIGITS] == at_end)
    else $error("carry out of the last digit disagrees with the end flag");

endmodule
